// ----- rtl/u8seg_pkg.sv -----
package u8seg_pkg;

    // Segment kinds as they appear on seg_kind
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_SPACE = 2'd1;
    localparam logic [1:0] KIND_IDEO  = 2'd2;

    // Queue depths between the parts
    localparam int EVQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic [15:0] para_base;
        logic        para_last;
    } in_word_t;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_length;
        logic [1:0]  seg_kind;
        logic        seg_last;
        logic        offset_overflow;
    } out_word_t;

    // Control part of one decoded byte, handed from decoder to segmenter
    typedef struct packed {
        logic       place;  // a code point finishes on this byte
        logic [1:0] kind;   // class of that code point
        logic       last;   // final byte of the paragraph
        logic       sat;    // offset saturated so far in this paragraph
    } evt_ctl_t;

endpackage

// ----- rtl/u8seg_fifo.sv -----
module u8seg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/u8seg_front.sv -----
module u8seg_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  u8seg_pkg::in_word_t   in_word,
    output u8seg_pkg::evt_ctl_t   evt_ctl,
    output logic [OFFSET_BITS-1:0] evt_char_begin,
    output logic [OFFSET_BITS-1:0] evt_end_pos
);
    import u8seg_pkg::*;

    localparam int BW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam logic [OFFSET_BITS-1:0] LIMIT = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] cb_reg, cb_next;
    logic [20:0]            acc_reg, acc_next;
    logic [1:0]             pend_reg, pend_next;
    logic                   sat_reg, sat_next;
    logic                   first_reg, first_next;

    logic [BW-1:0]          base_ext;
    logic                   base_over;
    logic [OFFSET_BITS-1:0] pos;
    logic                   sat_start;
    logic                   at_lim;
    logic [1:0]             pend0;
    logic [20:0]            acc0;
    logic [20:0]            acc_dec;
    logic [1:0]             pend_dec;
    logic [20:0]            cp;
    logic                   done;
    logic                   truncated;
    logic [7:0]             b;

    function automatic logic [1:0] classify(input logic [20:0] c);
        logic [1:0] k;
        k = KIND_WORD;
        if (c == 21'h09 || c == 21'h20 || c == 21'hA0 || c == 21'h1680 ||
            (c >= 21'h2000 && c <= 21'h200A) || c == 21'h202F ||
            c == 21'h205F || c == 21'h3000)
        begin
            k = KIND_SPACE;
        end
        else if ((c >= 21'h2E80 && c <= 21'h9FFF) ||
                 (c >= 21'hF900 && c <= 21'hFAFF) ||
                 (c >= 21'h20000 && c <= 21'h3134F))
        begin
            k = KIND_IDEO;
        end
        return k;
    endfunction

    always_comb
    begin
        b         = in_word.text_byte;
        // clamp the paragraph base to the offset limit on the first byte
        base_ext  = BW'(in_word.para_base);
        base_over = (base_ext > BW'(LIMIT));
        pos       = first_reg ? (base_over ? LIMIT : base_ext[OFFSET_BITS-1:0]) : pos_reg;
        sat_start = first_reg ? base_over : sat_reg;
        at_lim    = (pos == LIMIT);
        pos_next  = at_lim ? LIMIT : pos + OFFSET_BITS'(1);
        sat_next  = sat_start | at_lim;

        pend0 = first_reg ? 2'd0 : pend_reg;
        acc0  = first_reg ? 21'd0 : acc_reg;

        cb_next  = cb_reg;
        acc_dec  = acc0;
        pend_dec = pend0;
        cp       = acc0;
        done     = 1'b0;
        if (pend0 == 2'd0)
        begin
            cb_next = pos;
            if (!b[7])
            begin
                done = 1'b1;
                cp   = {14'd0, b[6:0]};
            end
            else if (b[7:5] == 3'b110)
            begin
                acc_dec  = {16'd0, b[4:0]};
                pend_dec = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc_dec  = {17'd0, b[3:0]};
                pend_dec = 2'd2;
            end
            else
            begin
                acc_dec  = {18'd0, b[2:0]};
                pend_dec = 2'd3;
            end
        end
        else
        begin
            // shift in six payload bits of a continuation byte
            acc_dec  = {acc0[14:0], b[5:0]};
            pend_dec = pend0 - 2'd1;
            cp       = acc_dec;
            done     = (pend_dec == 2'd0);
        end

        // a paragraph cut inside a code point closes it as a word
        truncated = in_word.para_last && (pend_dec != 2'd0);

        acc_next   = in_word.para_last ? 21'd0 : acc_dec;
        pend_next  = in_word.para_last ? 2'd0 : pend_dec;
        first_next = in_word.para_last;

        evt_ctl.place  = done | truncated;
        evt_ctl.kind   = truncated ? KIND_WORD : classify(cp);
        evt_ctl.last   = in_word.para_last;
        evt_ctl.sat    = sat_next;
        evt_char_begin = cb_next;
        evt_end_pos    = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cb_reg    <= '0;
            acc_reg   <= '0;
            pend_reg  <= '0;
            sat_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            cb_reg    <= cb_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            sat_reg   <= sat_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- rtl/u8seg_back.sv -----
module u8seg_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_empty,
    input  u8seg_pkg::evt_ctl_t    evt_ctl,
    input  logic [OFFSET_BITS-1:0] evt_char_begin,
    input  logic [OFFSET_BITS-1:0] evt_end_pos,
    input  logic [2:0]             outq_free,
    output logic                   evt_pop,
    output logic [1:0]             push_cnt,
    output u8seg_pkg::out_word_t   push_data0,
    output u8seg_pkg::out_word_t   push_data1
);
    import u8seg_pkg::*;

    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [1:0]             class_reg, class_next;
    logic                   open_reg, open_next;

    logic                   merge;
    logic                   emit_a;
    logic                   emit_b;
    logic [1:0]             need;
    out_word_t              word_a;
    out_word_t              word_b;

    function automatic logic [15:0] trim16(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    always_comb
    begin
        // same-kind words and spaces extend the open segment
        merge  = open_reg && (evt_ctl.kind == class_reg) && (evt_ctl.kind != KIND_IDEO);
        emit_a = evt_ctl.place && open_reg && !merge;
        emit_b = evt_ctl.last;
        need   = {1'b0, emit_a} + {1'b0, emit_b};

        begin_next = begin_reg;
        class_next = class_reg;
        open_next  = open_reg;
        if (evt_ctl.place && !merge)
        begin
            begin_next = evt_char_begin;
            class_next = evt_ctl.kind;
            open_next  = 1'b1;
        end

        word_a.seg_start       = trim16(begin_reg);
        word_a.seg_length      = trim16(evt_char_begin - begin_reg);
        word_a.seg_kind        = class_reg;
        word_a.seg_last        = 1'b0;
        word_a.offset_overflow = evt_ctl.sat;

        word_b.seg_start       = trim16(begin_next);
        word_b.seg_length      = trim16(evt_end_pos - begin_next);
        word_b.seg_kind        = class_next;
        word_b.seg_last        = 1'b1;
        word_b.offset_overflow = evt_ctl.sat;

        // take the next event only when its words fit
        evt_pop    = !evt_empty && ({1'b0, need} <= outq_free);
        push_cnt   = evt_pop ? need : 2'd0;
        push_data0 = emit_a ? word_a : word_b;
        push_data1 = word_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= '0;
            class_reg <= KIND_WORD;
            open_reg  <= 1'b0;
        end
        else if (evt_pop)
        begin
            begin_reg <= begin_next;
            class_reg <= class_next;
            open_reg  <= open_next && !evt_ctl.last;
        end
    end

endmodule

// ----- rtl/u8seg_outq.sv -----
module u8seg_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  u8seg_pkg::out_word_t push_data0,
    input  u8seg_pkg::out_word_t push_data1,
    input  logic                 pop,
    output u8seg_pkg::out_word_t dout,
    output logic                 empty,
    output logic [2:0]           free
);
    import u8seg_pkg::*;

    localparam int AW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    out_word_t     mem_reg [OUTQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          popped;
    logic [AW-1:0] wr_ptr_plus1;

    always_comb
    begin
        empty        = (count_reg == '0);
        free         = 3'(CW'(OUTQ_DEPTH) - count_reg);
        dout         = mem_reg[rd_ptr_reg];
        popped       = pop && !empty;
        wr_ptr_plus1 = wr_ptr_reg + AW'(1);
        wr_ptr_next  = wr_ptr_reg + AW'(push_cnt);
        rd_ptr_next  = popped ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next   = count_reg + CW'(push_cnt) - CW'(popped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

// ----- rtl/utf8_text_segmenter_unit.sv -----
// A byte's result words pass the event queue, then the result queue, to the result ports.
// The unit takes one byte per cycle while the event queue has room; one result word leaves
// per pop, so a paragraph's final byte that closes two segments takes an extra pop.
// The decoder is set apart from the segmenter by a 4-entry event queue, and the segmenter
// writes into a 4-entry result queue that takes up to two words per cycle.
// Reset (rst_n low, asynchronous) empties both queues; the next byte starts a paragraph.
module utf8_text_segmenter_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  u8seg_pkg::in_word_t  in_data,
    output logic                 empty,
    input  logic                 pop,
    output u8seg_pkg::out_word_t out_data
);
    import u8seg_pkg::*;

    localparam int EVW = $bits(evt_ctl_t) + 2 * OFFSET_BITS;

    // decoder side
    logic                   accept;
    evt_ctl_t               f_ctl;
    logic [OFFSET_BITS-1:0] f_char_begin;
    logic [OFFSET_BITS-1:0] f_end_pos;

    // event queue head
    logic [EVW-1:0]         evq_dout;
    logic                   evq_empty;
    evt_ctl_t               h_ctl;
    logic [OFFSET_BITS-1:0] h_char_begin;
    logic [OFFSET_BITS-1:0] h_end_pos;

    // segmenter to result queue
    logic                   evt_pop;
    logic [1:0]             outq_push_cnt;
    out_word_t              outq_data0;
    out_word_t              outq_data1;
    logic [2:0]             outq_free;

    // take a byte whenever the event queue has a slot
    assign accept = push && !full;

    u8seg_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_word        (in_data),
        .evt_ctl        (f_ctl),
        .evt_char_begin (f_char_begin),
        .evt_end_pos    (f_end_pos)
    );

    // one event per accepted byte, decoupling decode from segment assembly
    u8seg_fifo #(
        .WIDTH (EVW),
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   ({f_ctl, f_char_begin, f_end_pos}),
        .pop   (evt_pop),
        .dout  (evq_dout),
        .full  (full),
        .empty (evq_empty)
    );

    assign {h_ctl, h_char_begin, h_end_pos} = evq_dout;

    // merge runs and emit closed segments; stall the event queue when words do not fit
    u8seg_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_empty      (evq_empty),
        .evt_ctl        (h_ctl),
        .evt_char_begin (h_char_begin),
        .evt_end_pos    (h_end_pos),
        .outq_free      (outq_free),
        .evt_pop        (evt_pop),
        .push_cnt       (outq_push_cnt),
        .push_data0     (outq_data0),
        .push_data1     (outq_data1)
    );

    // hold finished words until the consumer pops them
    u8seg_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (outq_push_cnt),
        .push_data0 (outq_data0),
        .push_data1 (outq_data1),
        .pop        (pop),
        .dout       (out_data),
        .empty      (empty),
        .free       (outq_free)
    );

`ifndef ASSERT_OFF
    // never write more words than the result queue has room for
    assert property (@(posedge clk) disable iff (!rst_n)
        (outq_push_cnt != 2'd0) |-> ({1'b0, outq_push_cnt} <= outq_free))
        else $error("result queue overrun");

    // segmenter draws events only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_pop |-> !evq_empty)
        else $error("event queue underrun");

    // a paragraph-end event always yields a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_pop && h_ctl.last) |-> (outq_push_cnt != 2'd0))
        else $error("paragraph end produced no segment");

    // a word marked last is never followed in the same write by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (outq_push_cnt == 2'd2) |-> (!outq_data0.seg_last && outq_data1.seg_last))
        else $error("bad order of segment words");
`endif

endmodule

// ----- dv/utf8_text_segmenter_unit_test.sv -----
`timescale 1ns / 100ps

module utf8_text_segmenter_unit_test;

    import u8seg_pkg::*;

    // Run shape
    localparam int RANDOM_BYTES = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_ROWS     = 25;
    localparam int REPORT_MAX   = 10;
    localparam logic [15:0] OFS_LIMIT = 16'hFFFF;

    // One row of the directed table. When typed is set the row is the final byte of a
    // one-byte paragraph and its single result word is written out right here.
    typedef struct packed {
        logic [7:0]  b;
        logic [15:0] base;
        logic        last;
        logic        typed;
        logic [15:0] x_start;
        logic [15:0] x_len;
        logic [1:0]  x_kind;
        logic        x_ovf;
    } dir_row_t;

    // One byte waiting to be pushed, with its hand-written result when it has one
    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } feed_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  in_data;
    logic      empty;
    logic      pop;
    out_word_t out_data;

    bit        traffic_on;
    dir_row_t  dir_table [0:DIR_ROWS-1];
    feed_t     byte_feed [$];
    out_word_t seg_expect [$];
    logic [7:0] para_bytes [$];
    int        last_char_len;

    // Shadow copy of the segmenter state
    logic [15:0] byte_pos;
    logic [15:0] seg_begin;
    logic [1:0]  seg_class;
    logic        seg_open;
    logic [20:0] accum;
    logic [1:0]  pending;
    logic [15:0] char_begin;
    logic        sat_flag;
    logic        first_flag;
    out_word_t   step_res [0:1];
    int          step_n;

    // Run statistics
    int cycle_count;
    int bytes_in;
    int paras_in;
    int segs_checked;
    int kind_seen [0:3];
    int ovf_seen;
    int mismatch_count;

    utf8_text_segmenter_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Segment predictor
    // ------------------------------------------------------------------

    // Whitespace, ideograph or word for one code point
    function automatic logic [1:0] char_class(input logic [20:0] cp);
        if (cp == 21'h09 || cp == 21'h20 || cp == 21'hA0 || cp == 21'h1680 ||
            (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h202F ||
            cp == 21'h205F || cp == 21'h3000)
            return KIND_SPACE;
        if ((cp >= 21'h2E80 && cp <= 21'h9FFF) ||
            (cp >= 21'hF900 && cp <= 21'hFAFF) ||
            (cp >= 21'h20000 && cp <= 21'h3134F))
            return KIND_IDEO;
        return KIND_WORD;
    endfunction

    // Append one finished segment to the results of the current byte
    task automatic seg_emit(input logic [15:0] start, input logic [15:0] len,
                            input logic [1:0] kind, input logic last);
        out_word_t r;
        r.seg_start       = start;
        r.seg_length      = len;
        r.seg_kind        = kind;
        r.seg_last        = last;
        r.offset_overflow = sat_flag;
        step_res[step_n]  = r;
        step_n++;
    endtask

    // Place a finished code point: merge it into the open run, or close that run
    // and open a new one at the code point's lead byte
    task automatic seg_place(input logic [1:0] kind);
        if (seg_open && kind == seg_class && kind != KIND_IDEO)
            return;
        if (seg_open)
            seg_emit(seg_begin, char_begin - seg_begin, seg_class, 1'b0);
        seg_begin = char_begin;
        seg_class = kind;
        seg_open  = 1'b1;
    endtask

    // Advance the shadow state by one accepted byte; results land in step_res
    task automatic seg_step(input in_word_t w);
        logic [15:0] pos;
        logic [7:0]  b;
        b      = w.text_byte;
        step_n = 0;
        // A 16-bit para_base can never exceed the limit, so no clamp is needed here
        if (first_flag)
        begin
            sat_flag   = 1'b0;
            byte_pos   = w.para_base;
            seg_open   = 1'b0;
            pending    = 2'd0;
            accum      = '0;
            first_flag = 1'b0;
        end
        pos = byte_pos;
        if (pos == OFS_LIMIT)
            sat_flag = 1'b1;
        else
            byte_pos = pos + 16'd1;

        if (pending == 2'd0)
        begin
            char_begin = pos;
            if (b < 8'h80)
                seg_place(char_class({13'd0, b}));
            else if ((b & 8'hE0) == 8'hC0)
            begin
                accum   = {16'd0, b[4:0]};
                pending = 2'd1;
            end
            else if ((b & 8'hF0) == 8'hE0)
            begin
                accum   = {17'd0, b[3:0]};
                pending = 2'd2;
            end
            else
            begin
                // stray continuation bytes and 0xF8..0xFF also start four bytes
                accum   = {18'd0, b[2:0]};
                pending = 2'd3;
            end
        end
        else
        begin
            accum   = {accum[14:0], b[5:0]};
            pending = pending - 2'd1;
            if (pending == 2'd0)
                seg_place(char_class(accum));
        end

        if (w.para_last)
        begin
            // a code point cut short by the paragraph end counts as a word
            if (pending != 2'd0)
            begin
                seg_place(KIND_WORD);
                pending = 2'd0;
            end
            seg_emit(seg_begin, byte_pos - seg_begin, seg_class, 1'b1);
            seg_open   = 1'b0;
            accum      = '0;
            first_flag = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Random paragraph builder
    // ------------------------------------------------------------------

    // Pick one code point (or a raw noise byte) and append its UTF-8 bytes
    task automatic add_random_char();
        int c;
        logic [20:0] cp;
        c = $urandom_range(0, 99);
        if (c < 30)
            cp = 21'($urandom_range(8'h21, 8'h7E));
        else if (c < 45)
            cp = $urandom_range(0, 1) ? 21'h20 : 21'h09;
        else if (c < 55)
        begin
            case ($urandom_range(0, 5))
                0: cp = 21'hA0;
                1: cp = 21'h1680;
                2: cp = 21'h2000 + 21'($urandom_range(0, 10));
                3: cp = 21'h202F;
                4: cp = 21'h205F;
                default: cp = 21'h3000;
            endcase
        end
        else if (c < 70)
        begin
            case ($urandom_range(0, 2))
                0: cp = 21'($urandom_range(21'h2E80, 21'h9FFF));
                1: cp = 21'($urandom_range(21'hF900, 21'hFAFF));
                default: cp = 21'($urandom_range(21'h20000, 21'h3134F));
            endcase
        end
        else if (c < 85)
        begin
            case ($urandom_range(0, 2))
                0: cp = 21'($urandom_range(21'h80, 21'h7FF));
                1: cp = 21'($urandom_range(21'h800, 21'hFFFF));
                default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
            endcase
        end
        else if (c < 93)
        begin
            // class edges and control characters next to the tab
            case ($urandom_range(0, 15))
                0: cp = 21'h00;
                1: cp = 21'h08;
                2: cp = 21'h0A;
                3: cp = 21'h1F;
                4: cp = 21'h7F;
                5: cp = 21'h2E7F;
                6: cp = 21'h2E80;
                7: cp = 21'h9FFF;
                8: cp = 21'hA000;
                9: cp = 21'hF8FF;
                10: cp = 21'hFB00;
                11: cp = 21'h1FFFF;
                12: cp = 21'h3134F;
                13: cp = 21'h31350;
                14: cp = 21'h200B;
                default: cp = 21'h1FFF;
            endcase
        end
        else
        begin
            para_bytes.push_back(8'($urandom_range(0, 255)));
            last_char_len = 1;
            return;
        end

        if (cp < 21'h80)
        begin
            para_bytes.push_back(cp[7:0]);
            last_char_len = 1;
        end
        else if (cp < 21'h800)
        begin
            para_bytes.push_back({3'b110, cp[10:6]});
            para_bytes.push_back({2'b10, cp[5:0]});
            last_char_len = 2;
        end
        else if (cp < 21'h10000)
        begin
            para_bytes.push_back({4'b1110, cp[15:12]});
            para_bytes.push_back({2'b10, cp[11:6]});
            para_bytes.push_back({2'b10, cp[5:0]});
            last_char_len = 3;
        end
        else
        begin
            para_bytes.push_back({5'b11110, cp[20:18]});
            para_bytes.push_back({2'b10, cp[17:12]});
            para_bytes.push_back({2'b10, cp[11:6]});
            para_bytes.push_back({2'b10, cp[5:0]});
            last_char_len = 4;
        end
    endtask

    // Build one paragraph and queue its bytes: mostly well-formed text, sometimes
    // cut inside the last code point, sometimes pure noise
    task automatic add_paragraph(input bit broken);
        logic [15:0] base;
        feed_t f;
        int pick;
        para_bytes.delete();
        if (broken)
        begin
            repeat ($urandom_range(1, 8))
                para_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                add_random_char();
            if ($urandom_range(0, 9) == 0 && last_char_len > 1)
                repeat ($urandom_range(1, last_char_len - 1))
                    void'(para_bytes.pop_back());
        end

        // keep some paragraphs near the top of the offset range so they saturate
        pick = $urandom_range(0, 9);
        if (pick < 8)
            base = 16'($urandom_range(0, 60000));
        else if (pick == 8)
            base = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        else
            base = 16'($urandom_range(0, 65535));

        foreach (para_bytes[i])
        begin
            f.w.text_byte = para_bytes[i];
            // only the first byte's base matters; scramble the rest
            f.w.para_base = (i == 0) ? base : 16'($urandom_range(0, 65535));
            f.w.para_last = (i == para_bytes.size() - 1);
            f.typed       = 1'b0;
            f.want        = '0;
            byte_feed.push_back(f);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        bit calm;
        if (traffic_on)
        begin
            // hold both sides busy for a stretch in the middle of the run
            calm    = (bytes_in >= 500) && (bytes_in < 800);
            push    <= (byte_feed.size() != 0) && (calm || $urandom_range(0, 99) >= 28);
            in_data <= (byte_feed.size() != 0) ? byte_feed[0].w : '0;
            pop     <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_word_t due;
        feed_t     f;
        bit        bad;
        if (rst_n)
        begin
            cycle_count++;

            // check the result word leaving the block against the oldest one due
            if (pop && !empty)
            begin
                if (seg_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected word: start %h len %h kind %0d last %b ovf %b",
                                 out_data.seg_start, out_data.seg_length,
                                 out_data.seg_kind, out_data.seg_last,
                                 out_data.offset_overflow);
                end
                else
                begin
                    due = seg_expect.pop_front();
                    bad = (out_data.seg_start !== due.seg_start) ||
                          (out_data.seg_length !== due.seg_length) ||
                          (out_data.seg_kind !== due.seg_kind) ||
                          (out_data.seg_last !== due.seg_last) ||
                          (out_data.offset_overflow !== due.offset_overflow);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("segment %0d mismatch (start len kind last ovf)",
                                     segs_checked);
                            $display("  want %h %h %0d %b %b", due.seg_start,
                                     due.seg_length, due.seg_kind, due.seg_last,
                                     due.offset_overflow);
                            $display("  got  %h %h %0d %b %b", out_data.seg_start,
                                     out_data.seg_length, out_data.seg_kind,
                                     out_data.seg_last, out_data.offset_overflow);
                        end
                    end
                    segs_checked++;
                    kind_seen[due.seg_kind]++;
                    if (due.offset_overflow)
                        ovf_seen++;
                end
            end

            // a byte went in: advance the shadow state and queue what it causes
            if (push && !full)
            begin
                f = byte_feed.pop_front();
                seg_step(f.w);
                if (f.typed)
                    seg_expect.push_back(f.want);
                else
                    for (int i = 0; i < step_n; i++)
                        seg_expect.push_back(step_res[i]);
                bytes_in++;
                if (f.w.para_last)
                    paras_in++;
            end

            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d result words still due",
                         cycle_count, seg_expect.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        feed_t f;
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        in_data        = '0;
        traffic_on     = 1'b0;
        cycle_count    = 0;
        bytes_in       = 0;
        paras_in       = 0;
        segs_checked   = 0;
        kind_seen      = '{0, 0, 0, 0};
        ovf_seen       = 0;
        mismatch_count = 0;
        last_char_len  = 1;

        // shadow state after reset
        byte_pos   = '0;
        seg_begin  = '0;
        seg_class  = KIND_WORD;
        seg_open   = 1'b0;
        accum      = '0;
        pending    = 2'd0;
        char_begin = '0;
        sat_flag   = 1'b0;
        first_flag = 1'b1;

        //                    byte   base      last  typed start    len     kind        ovf
        // one-byte paragraphs with their result written out
        dir_table[0]  = {8'h41, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'd1, KIND_WORD,  1'b0};
        // last offset already at the limit: zero length, overflow set
        dir_table[1]  = {8'h20, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'd0, KIND_SPACE, 1'b1};
        dir_table[2]  = {8'h09, 16'hFFFE, 1'b1, 1'b1, 16'hFFFE, 16'd1, KIND_SPACE, 1'b0};
        // lone lead and continuation bytes are cut short, and 0x7F is plain: each a one-byte word
        dir_table[3]  = {8'hFF, 16'h1234, 1'b1, 1'b1, 16'h1234, 16'd1, KIND_WORD,  1'b0};
        dir_table[4]  = {8'h7F, 16'h8000, 1'b1, 1'b1, 16'h8000, 16'd1, KIND_WORD,  1'b0};
        dir_table[5]  = {8'h80, 16'h00FF, 1'b1, 1'b1, 16'h00FF, 16'd1, KIND_WORD,  1'b0};
        // word, space, two ideographs in a row, tab, then a cut four-byte lead
        dir_table[6]  = {8'h61, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[7]  = {8'h20, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[8]  = {8'hE4, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[9]  = {8'hB8, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[10] = {8'h80, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[11] = {8'hE4, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[12] = {8'hB8, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[13] = {8'h80, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[14] = {8'h09, 16'h0064, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[15] = {8'hFF, 16'h0064, 1'b1, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        // no-break space, then a four-byte ideograph that ends the paragraph
        dir_table[16] = {8'hC2, 16'h0200, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[17] = {8'hA0, 16'h0200, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[18] = {8'hF0, 16'h0200, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[19] = {8'hA0, 16'h0200, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[20] = {8'h80, 16'h0200, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[21] = {8'h80, 16'h0200, 1'b1, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        // offsets run into the limit partway through the paragraph
        dir_table[22] = {8'h41, 16'hFFFD, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[23] = {8'h42, 16'hFFFD, 1'b0, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};
        dir_table[24] = {8'h20, 16'hFFFD, 1'b1, 1'b0, 16'h0000, 16'd0, KIND_WORD,  1'b0};

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            f.w.text_byte = dir_table[i].b;
            f.w.para_base = dir_table[i].base;
            f.w.para_last = dir_table[i].last;
            f.typed       = dir_table[i].typed;
            f.want        = {dir_table[i].x_start, dir_table[i].x_len, dir_table[i].x_kind,
                             1'b1, dir_table[i].x_ovf};
            byte_feed.push_back(f);
        end

        while (byte_feed.size() - DIR_ROWS < RANDOM_BYTES)
            add_paragraph($urandom_range(0, 99) < 15);

        // hold reset, then release it away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n      <= 1'b1;
        traffic_on <= 1'b1;

        // wait for every byte to go in and every result word to come back out
        while (byte_feed.size() != 0)
            @(negedge clk);
        while (seg_expect.size() != 0)
            @(negedge clk);
        // give any stray result word time to show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d paragraphs over %0d cycles", bytes_in, paras_in,
                 cycle_count);
        $display("checked %0d segments: %0d word, %0d space, %0d ideograph, %0d with overflow",
                 segs_checked, kind_seen[KIND_WORD], kind_seen[KIND_SPACE],
                 kind_seen[KIND_IDEO], ovf_seen);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/u8seg_pkg.sv
rtl/u8seg_fifo.sv
rtl/u8seg_front.sv
rtl/u8seg_back.sv
rtl/u8seg_outq.sv
rtl/utf8_text_segmenter_unit.sv
dv/utf8_text_segmenter_unit_test.sv
